// ----- rtl/spts_pkg.sv -----
`default_nettype none

package spts_pkg;

  // table geometry
  localparam int MAX_TERMS = 16;
  localparam int MAX_POWER = 31;

  // fixed field widths
  localparam int DataW   = 32;
  localparam int PowerW  = 5;
  localparam int ModeW   = 2;
  localparam int TcountW = 5;

  // derived widths
  localparam int IdxW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CntW   = $clog2(MAX_TERMS + 1);
  localparam int PowTabN = 2 ** PowerW;

  // operation codes
  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 2'd1;
  localparam logic [ModeW-1:0] MODE_EVAL   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic del_step;
    logic del_commit;
    logic pow_step;
    logic ev_issue;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             empty;
    logic             idx_last;
    logic             pow_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/spts_dp.sv -----
`default_nettype none

module spts_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  spts_pkg::cmd_t                cmd_i,
  output spts_pkg::stat_t               stat_o,
  input  wire [spts_pkg::ModeW-1:0]     mode_i,
  input  wire [spts_pkg::DataW-1:0]     coeff_i,
  input  wire [spts_pkg::PowerW-1:0]    power_i,
  input  wire [spts_pkg::DataW-1:0]     x_value_i,
  output logic [spts_pkg::DataW-1:0]    value_o,
  output logic [spts_pkg::TcountW-1:0]  term_count_o,
  output logic                          status_o
);
  import spts_pkg::*;

  // term table
  logic [DataW-1:0]  coef_q [MAX_TERMS];
  logic [PowerW-1:0] pow_q  [MAX_TERMS];
  // powers of x
  logic [DataW-1:0]  xpow_q [PowTabN];

  logic [ModeW-1:0]  mode_q;
  logic [DataW-1:0]  coeff_q;
  logic [PowerW-1:0] power_q;
  logic [DataW-1:0]  x_q;
  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   keep_q;
  logic [PowerW-1:0] k_q;
  logic [DataW-1:0]  prev_q;
  logic [DataW-1:0]  prod_q;
  logic              prod_v_q;
  logic [DataW-1:0]  acc_q;
  logic              status_q;

  logic              full;
  logic [DataW-1:0]  prod_d;
  logic [DataW-1:0]  prev_d;

  assign full   = (count_q >= CntW'(MAX_TERMS));
  assign prod_d = coef_q[idx_q] * xpow_q[pow_q[idx_q]];
  assign prev_d = prev_q * x_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INSERT;
      count_q  <= '0;
      idx_q    <= '0;
      keep_q   <= '0;
      k_q      <= '0;
      prod_v_q <= 1'b0;
      status_q <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.ev_issue;
      if (cmd_i.load) begin
        mode_q   <= mode_i;
        idx_q    <= '0;
        keep_q   <= '0;
        k_q      <= '0;
        status_q <= 1'b0;
      end
      if (cmd_i.insert) begin
        if (full) begin
          status_q <= 1'b1;
        end else if (int'(power_q) <= MAX_POWER) begin
          count_q <= count_q + CntW'(1);
        end
      end
      if (cmd_i.del_step) begin
        idx_q <= idx_q + IdxW'(1);
        if (pow_q[idx_q] != power_q) begin
          keep_q <= keep_q + CntW'(1);
        end
      end
      if (cmd_i.del_commit) begin
        count_q <= keep_q;
      end
      if (cmd_i.pow_step) begin
        k_q <= k_q + PowerW'(1);
      end
      if (cmd_i.ev_issue) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coeff_q <= coeff_i;
      power_q <= power_i;
      x_q     <= x_value_i;
      prev_q  <= DataW'(1);
      acc_q   <= '0;
    end
    if (cmd_i.insert && !full && (int'(power_q) <= MAX_POWER)) begin
      coef_q[count_q[IdxW-1:0]] <= coeff_q;
      pow_q[count_q[IdxW-1:0]]  <= power_q;
    end
    if (cmd_i.del_step && (pow_q[idx_q] != power_q)) begin
      coef_q[keep_q[IdxW-1:0]] <= coef_q[idx_q];
      pow_q[keep_q[IdxW-1:0]]  <= pow_q[idx_q];
    end
    if (cmd_i.pow_step) begin
      xpow_q[k_q] <= prev_q;
      prev_q      <= prev_d;
    end
    if (cmd_i.ev_issue) begin
      prod_q <= prod_d;
    end
    if (prod_v_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.idx_last = (CntW'(idx_q) == (count_q - CntW'(1)));
  assign stat_o.pow_last = (k_q == PowerW'(MAX_POWER));

  assign value_o      = (mode_q == MODE_EVAL) ? acc_q : '0;
  assign term_count_o = TcountW'(count_q);
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ----- rtl/spts_ctrl.sv -----
`default_nettype none

module spts_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  output logic             done_o,
  output spts_pkg::cmd_t   cmd_o,
  input  spts_pkg::stat_t  stat_i
);
  import spts_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDisp,
    StDelWalk,
    StDelCommit,
    StPow,
    StEval,
    StDrain,
    StResp
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (start) state_q <= StDisp;
        end
        StDisp: begin
          case (stat_i.mode)
            MODE_INSERT: state_q <= StResp;
            MODE_DELETE: state_q <= stat_i.empty ? StDelCommit : StDelWalk;
            MODE_EVAL:   state_q <= StPow;
            default:     state_q <= StResp;
          endcase
        end
        StDelWalk: begin
          if (stat_i.idx_last) state_q <= StDelCommit;
        end
        StDelCommit: state_q <= StResp;
        StPow: begin
          if (stat_i.pow_last) state_q <= stat_i.empty ? StDrain : StEval;
        end
        StEval: begin
          if (stat_i.idx_last) state_q <= StDrain;
        end
        StDrain: state_q <= StResp;
        StResp:  state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = (state_q == StResp);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == StIdle) && start;
    cmd_o.insert     = (state_q == StDisp) && (stat_i.mode == MODE_INSERT);
    cmd_o.del_step   = (state_q == StDelWalk);
    cmd_o.del_commit = (state_q == StDelCommit);
    cmd_o.pow_step   = (state_q == StPow);
    cmd_o.ev_issue   = (state_q == StEval);
  end

endmodule

`default_nettype wire

// ----- rtl/sparse_polynomial_term_store.sv -----
// insert and unused mode go from dispatch straight to the result beat; delete walks the
// stored terms, compacting the kept ones, then commits the new count
// one operation at a time: busy high after acceptance through the done_o beat
// the evaluate time is set by the build of the x power table, one multiply per cycle,
// then one term per cycle through the term multiplier into the accumulator
// reset: rst_ni async active low empties the table; the receiver cannot stall done_o
`default_nettype none

module sparse_polynomial_term_store (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire        [spts_pkg::ModeW-1:0]   mode_i,
  input  wire signed [spts_pkg::DataW-1:0]   coeff_i,
  input  wire        [spts_pkg::PowerW-1:0]  power_i,
  input  wire signed [spts_pkg::DataW-1:0]   x_value_i,
  output logic                               done_o,
  output logic signed [spts_pkg::DataW-1:0]  value_o,
  output logic       [spts_pkg::TcountW-1:0] term_count_o,
  output logic                               status_o
);
  import spts_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  logic [DataW-1:0] value;

  // sequencer: dispatch, delete walk, power table build, term walk, result beat
  spts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // datapath: term table, x power table, multiplier and accumulator
  spts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .coeff_i      (coeff_i),
    .power_i      (power_i),
    .x_value_i    (x_value_i),
    .value_o      (value),
    .term_count_o (term_count_o),
    .status_o     (status_o)
  );

  // result fields hold from a result beat until the next accept; value is zero outside evaluate
  assign value_o = value;

`ifndef SYNTHESIS
  // a result beat only ends an accepted operation
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  // accepted beat makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // stored count never passes the table size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(term_count_o) <= MAX_TERMS) else $error("term count overflow");

  // a refused insert never reports a value
  a_status_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (value_o == '0)) else $error("refusal with value");

  // busy drops right after the result beat
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after done");
`endif

endmodule

`default_nettype wire
